FILE: rtl/core/rthg_pkg.sv
// ----------------------------------------------------------------------------
// rthg_pkg
// Shared types and constants for the RTP header and timestamp generator.
// ----------------------------------------------------------------------------
package rthg_pkg;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_SOURCE_ID  = 1'b0;
    localparam logic REG_SKEW_LIMIT = 1'b1;

    localparam logic [15:0] SKEW_LIMIT_RESET = 16'd640;

    // header constants
    localparam logic [1:0] RTP_VERSION = 2'b10;
    localparam logic [7:0] G722_CLOCK_KHZ = 8'd8;

    // floor(n / 20) = (n * RECIP_20) >> RECIP_20_SHIFT for any 32-bit n
    localparam logic [31:0] RECIP_20       = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_20_SHIFT = 36;
    localparam int unsigned QUOT_W         = 64 - RECIP_20_SHIFT;

    typedef struct packed {
        logic [31:0] source_id;
        logic [15:0] skew_limit;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        delivery_given;
        logic [31:0] delivery_ms;
        logic        has_timing;
        logic [31:0] frame_time_ms;
        logic [15:0] sample_count;
        logic [7:0]  clock_khz;
        logic        is_g722;
        logic [6:0]  payload_type;
    } t_frame;

    // frame after elapsed-time stage; clock and samples already adjusted for G.722
    typedef struct packed {
        logic [31:0] elapsed_ms;
        logic [7:0]  rate_khz;
        logic [15:0] samples;
        logic        has_timing;
        logic        delivery_given;
        logic [31:0] frame_time_ms;
        logic [6:0]  payload_type;
    } t_timed;

endpackage

FILE: rtl/core/rthg_apb_regs.sv
// ----------------------------------------------------------------------------
// rthg_apb_regs
// APB register file: source identifier and skew limit.
// ----------------------------------------------------------------------------
module rthg_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rthg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rthg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rthg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output rthg_pkg::t_cfg                     o_cfg
);

    rthg_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_id  <= '0;
            r_cfg.skew_limit <= rthg_pkg::SKEW_LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                rthg_pkg::REG_SOURCE_ID:  r_cfg.source_id  <= pwdata;
                rthg_pkg::REG_SKEW_LIMIT: r_cfg.skew_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rthg_pkg::REG_SOURCE_ID:  prdata = r_cfg.source_id;
            rthg_pkg::REG_SKEW_LIMIT: prdata = {16'd0, r_cfg.skew_limit};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/rthg_time_path.sv
// ----------------------------------------------------------------------------
// rthg_time_path
// Three stages: divide by 20, round down to 20 ms, elapsed time since last send.
// ----------------------------------------------------------------------------
module rthg_time_path (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rthg_pkg::t_frame     i_frame,
    output logic                 o_ready,
    output logic                 o_valid,
    output rthg_pkg::t_timed     o_timed,
    input  logic                 i_ready
);

    logic                               r2_v, r3_v, r4_v;
    logic                               en2, en3, en4;
    rthg_pkg::t_frame                   r2_frame, r3_frame;
    logic [rthg_pkg::QUOT_W-1:0]        r2_quot;
    logic [31:0]                        r3_floor;
    rthg_pkg::t_timed                   r4_timed;
    logic [31:0]                        r_last_send_ms;
    logic                               r_time_known;

    logic [63:0]                        quot_prod;
    logic [31:0]                        quot32, quot_x20, n3_floor;
    logic [31:0]                        send_ms, base_ms, diff_ms;
    rthg_pkg::t_timed                   n4_timed;

    assign en4     = !r4_v || i_ready;
    assign en3     = !r3_v || en4;
    assign en2     = !r2_v || en3;
    assign o_ready = en2;

    // stage 2: quotient by 20 through reciprocal multiply
    assign quot_prod = 64'(i_frame.now_ms) * 64'(rthg_pkg::RECIP_20);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_frame <= i_frame;
            r2_quot  <= quot_prod[63:rthg_pkg::RECIP_20_SHIFT];
        end
    end

    // stage 3: now rounded down to a 20 ms boundary
    assign quot32   = 32'(r2_quot);
    assign quot_x20 = (quot32 << 4) + (quot32 << 2);
    assign n3_floor = quot_x20;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_frame <= r2_frame;
            r3_floor <= n3_floor;
        end
    end

    // stage 4: elapsed ms, negative clamps to zero
    assign send_ms = r3_frame.delivery_given ? r3_frame.delivery_ms : r3_frame.now_ms;
    assign base_ms = r_time_known ? r_last_send_ms : r3_floor;
    assign diff_ms = send_ms - base_ms;

    always_comb begin
        n4_timed.elapsed_ms     = diff_ms[31] ? 32'd0 : diff_ms;
        n4_timed.rate_khz       = r3_frame.is_g722 ? rthg_pkg::G722_CLOCK_KHZ
                                                   : r3_frame.clock_khz;
        n4_timed.samples        = r3_frame.is_g722 ? {1'b0, r3_frame.sample_count[15:1]}
                                                   : r3_frame.sample_count;
        n4_timed.has_timing     = r3_frame.has_timing;
        n4_timed.delivery_given = r3_frame.delivery_given;
        n4_timed.frame_time_ms  = r3_frame.frame_time_ms;
        n4_timed.payload_type   = r3_frame.payload_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v           <= 1'b0;
            r_time_known   <= 1'b0;
            r_last_send_ms <= '0;
        end else if (en4) begin
            r4_v <= r3_v;
            if (r3_v) begin
                r_time_known   <= 1'b1;
                r_last_send_ms <= send_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_timed <= n4_timed;
        end
    end

    assign o_valid = r4_v;
    assign o_timed = r4_timed;

endmodule

FILE: rtl/core/rthg_stamp_path.sv
// ----------------------------------------------------------------------------
// rthg_stamp_path
// Products, deviation check, timestamp update and the output register.
// ----------------------------------------------------------------------------
module rthg_stamp_path (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rthg_pkg::t_timed     i_timed,
    input  logic [15:0]          i_skew_limit,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [31:0]          o_header_word0,
    output logic [31:0]          o_header_timestamp,
    input  logic                 i_ready
);

    logic        r5_v, r6_v, r7_v, r8_v;
    logic        en5, en6, en7, en8;

    logic [31:0] r5_ms_prod, r5_ft_prod;
    logic [15:0] r5_samples;
    logic        r5_has_timing, r5_check;
    logic [6:0]  r5_pt;

    logic [31:0] r6_ms_prod, r6_ft_prod, r6_dev;
    logic [15:0] r6_samples;
    logic        r6_has_timing, r6_check;
    logic [6:0]  r6_pt;

    logic [31:0] r7_ms_prod, r7_ft_prod;
    logic [15:0] r7_samples;
    logic        r7_has_timing, r7_snap, r7_mark;
    logic [6:0]  r7_pt;

    logic [31:0] r_last_stamp, r_word0;
    logic [15:0] r_sequence;

    logic [31:0] dev_mag, n_last_stamp;
    logic        within_skew;

    assign en8     = !r8_v || i_ready;
    assign en7     = !r7_v || en8;
    assign en6     = !r6_v || en7;
    assign en5     = !r5_v || en6;
    assign o_ready = en5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            if (en5) r5_v <= i_valid;
            if (en6) r6_v <= r5_v;
            if (en7) r7_v <= r6_v;
        end
    end

    // stage 5: the two rate products, wrapping at 32 bits
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_ms_prod    <= i_timed.elapsed_ms * 32'(i_timed.rate_khz);
            r5_ft_prod    <= i_timed.frame_time_ms * 32'(i_timed.rate_khz);
            r5_samples    <= i_timed.samples;
            r5_has_timing <= i_timed.has_timing;
            r5_check      <= !i_timed.has_timing && !i_timed.delivery_given;
            r5_pt         <= i_timed.payload_type;
        end
    end

    // stage 6: stamp minus prediction reduces to product minus samples
    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_ms_prod    <= r5_ms_prod;
            r6_ft_prod    <= r5_ft_prod;
            r6_dev        <= r5_ms_prod - 32'(r5_samples);
            r6_samples    <= r5_samples;
            r6_has_timing <= r5_has_timing;
            r6_check      <= r5_check;
            r6_pt         <= r5_pt;
        end
    end

    // stage 7: magnitude against skew limit
    assign dev_mag     = r6_dev[31] ? (32'd0 - r6_dev) : r6_dev;
    assign within_skew = dev_mag < 32'(i_skew_limit);

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_ms_prod    <= r6_ms_prod;
            r7_ft_prod    <= r6_ft_prod;
            r7_samples    <= r6_samples;
            r7_has_timing <= r6_has_timing;
            r7_snap       <= r6_check && within_skew;
            r7_mark       <= r6_check && !within_skew;
            r7_pt         <= r6_pt;
        end
    end

    // stage 8: timestamp state and header assembly
    always_comb begin
        if (r7_has_timing) begin
            n_last_stamp = r7_ft_prod;
        end else if (r7_snap) begin
            n_last_stamp = r_last_stamp + 32'(r7_samples);
        end else begin
            n_last_stamp = r_last_stamp + r7_ms_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v         <= 1'b0;
            r_last_stamp <= '0;
            r_sequence   <= '0;
        end else if (en8) begin
            r8_v <= r7_v;
            if (r7_v) begin
                r_last_stamp <= n_last_stamp;
                r_sequence   <= r_sequence + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en8) begin
            r_word0 <= {rthg_pkg::RTP_VERSION, 6'd0, r7_mark, r7_pt, r_sequence};
        end
    end

    assign o_valid            = r8_v;
    assign o_header_word0     = r_word0;
    assign o_header_timestamp = r_last_stamp;

endmodule

FILE: rtl/core/rtp_header_timestamp_generator_core.sv
// ----------------------------------------------------------------------------
// rtp_header_timestamp_generator_core
// RTP fixed-header generator: one frame descriptor in, three header words out.
// ----------------------------------------------------------------------------
// Takes one frame descriptor per cycle unless the header output stalls, and
// passes it through eight register stages (input register, reciprocal divide
// by 20, 20 ms rounding, elapsed time, rate products, deviation, skew compare,
// timestamp/output register). Each stage carries its own valid bit, so bubbles
// close up and new beats are taken while a finished header waits at the output.
// Sequence number, last timestamp and last send time are updated in order
// inside the pipe: the send time at the elapsed stage, the timestamp and
// sequence at the output stage. Write the APB registers only while no frame
// is in flight.
module rtp_header_timestamp_generator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // frame descriptor channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [31:0]                       i_now_ms,
    input  logic                              i_delivery_given,
    input  logic [31:0]                       i_delivery_ms,
    input  logic                              i_has_timing,
    input  logic [31:0]                       i_frame_time_ms,
    input  logic [15:0]                       i_sample_count,
    input  logic [7:0]                        i_clock_khz,
    input  logic                              i_is_g722,
    input  logic [6:0]                        i_payload_type,
    // header channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [31:0]                       o_header_word0,
    output logic [31:0]                       o_header_timestamp,
    output logic [31:0]                       o_header_source,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rthg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rthg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rthg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    rthg_pkg::t_cfg   cfg;
    rthg_pkg::t_frame r1_frame;
    logic             r1_v;
    logic             en1;
    logic             time_ready, time_valid, stamp_ready;
    rthg_pkg::t_timed timed;

    rthg_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    assign en1     = !r1_v || time_ready;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_frame.now_ms         <= i_now_ms;
            r1_frame.delivery_given <= i_delivery_given;
            r1_frame.delivery_ms    <= i_delivery_ms;
            r1_frame.has_timing     <= i_has_timing;
            r1_frame.frame_time_ms  <= i_frame_time_ms;
            r1_frame.sample_count   <= i_sample_count;
            r1_frame.clock_khz      <= i_clock_khz;
            r1_frame.is_g722        <= i_is_g722;
            r1_frame.payload_type   <= i_payload_type;
        end
    end

    rthg_time_path u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_frame (r1_frame),
        .o_ready (time_ready),
        .o_valid (time_valid),
        .o_timed (timed),
        .i_ready (stamp_ready)
    );

    rthg_stamp_path u_stamp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (time_valid),
        .i_timed            (timed),
        .i_skew_limit       (cfg.skew_limit),
        .o_ready            (stamp_ready),
        .o_valid            (o_valid),
        .o_header_word0     (o_header_word0),
        .o_header_timestamp (o_header_timestamp),
        .i_ready            (i_ready)
    );

    // source is to be changed by the user only while idle; the block does not enforce it
    assign o_header_source = cfg.source_id;

endmodule

FILE: rtl/core/rthg_checker.sv
// ----------------------------------------------------------------------------
// rthg_checker
// Port-level checks for the RTP header generator, bound to the top level.
// ----------------------------------------------------------------------------
module rthg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_header_word0,
    input logic        pready
);

    logic [15:0] r_exp_seq;

    // sequence seen on delivered beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq <= '0;
        end else if (o_valid && i_ready) begin
            r_exp_seq <= r_exp_seq + 16'd1;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("header valid after reset");

    a_seq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_header_word0[15:0] == r_exp_seq)
        else $error("sequence number skipped or repeated");

    a_fixed_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_header_word0[31:30] == rthg_pkg::RTP_VERSION)
                    && (o_header_word0[29:24] == 6'd0))
        else $error("bad version or reserved bits in header");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_header_word0))
        else $error("stalled header beat changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind rtp_header_timestamp_generator_core rthg_checker u_rthg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_header_word0 (o_header_word0),
    .pready         (pready)
);
